// ===== hw/rtl/fpba_pkg.sv =====
// fpba_pkg: shared constants, codes and request/result types for the
// fit-policy block allocator. No dependencies.
package fpba_pkg;

  // table geometry
  localparam int NumBlocks = 16;
  localparam int SizeW     = 16;
  localparam int IdxW      = $clog2(NumBlocks);
  localparam int CountW    = $clog2(NumBlocks + 1);

  // command codes
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_ALLOC = 1'b1;

  // policy codes
  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;
  localparam logic [1:0] POL_NEXT  = 2'd3;

  // result status codes
  localparam logic [1:0] ST_LOADED  = 2'd0;
  localparam logic [1:0] ST_GRANTED = 2'd1;
  localparam logic [1:0] ST_REFUSED = 2'd2;

  // input request item
  typedef struct packed {
    logic             cmd;
    logic [1:0]       policy;
    logic [SizeW-1:0] request_size;
    logic [IdxW-1:0]  load_index;
    logic [SizeW-1:0] load_size;
  } req_t;

  // result item
  typedef struct packed {
    logic [1:0]       status;
    logic [IdxW-1:0]  block_index;
    logic [SizeW-1:0] remaining_size;
  } rsp_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;     // write a block's free size and post its result
    logic capture;  // latch an allocate request and set up the scan
    logic step;     // examine one table entry
    logic finish;   // commit the grant and post the result
  } ctl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic scan_last;  // the entry under examination is the final one
  } dp_sts_t;

endpackage

// ===== hw/rtl/fpba_ctrl.sv =====
// fpba_ctrl: sequencing state machine of the fit-policy block allocator.
// Depends on fpba_pkg for the command and status types.
module fpba_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic               req_alloc_i,
  input  fpba_pkg::dp_sts_t  sts_i,
  output fpba_pkg::ctl_cmd_t cmd_o,
  output logic               busy,
  output logic               done_o
);
  import fpba_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0] state_q, state_d;
  logic       done_q, done_d;

  // next state and datapath commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          if (req_alloc_i == CMD_ALLOC) begin
            cmd_o.capture = 1'b1;
            state_d       = S_SCAN;
          end else begin
            cmd_o.load = 1'b1;
          end
        end
      end
      S_SCAN: begin
        cmd_o.step = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // result strobe follows the cycle that posts a result
  assign done_d = cmd_o.load | cmd_o.finish;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule

// ===== hw/rtl/fpba_dpath.sv =====
// fpba_dpath: free-size table, scan registers, next-fit pointer, block count
// and result register of the fit-policy block allocator. Depends on fpba_pkg.
module fpba_dpath (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  fpba_pkg::req_t           req_i,
  input  fpba_pkg::ctl_cmd_t       cmd_i,
  input  logic                     cfg_we_i,
  input  logic [fpba_pkg::CountW-1:0] cfg_wdata_i,
  output fpba_pkg::dp_sts_t        sts_o,
  output fpba_pkg::rsp_t           rsp_o
);
  import fpba_pkg::*;

  // free size per block, undefined until loaded
  logic [SizeW-1:0]  blk_free_q [NumBlocks];

  req_t              req_q;
  logic [IdxW-1:0]   pos_q, pos_d;
  logic [IdxW-1:0]   cnt_q, cnt_d;
  logic              found_q, found_d;
  logic [IdxW-1:0]   best_idx_q, best_idx_d;
  logic [SizeW-1:0]  best_val_q, best_val_d;
  logic [IdxW-1:0]   np_q, np_d;
  logic [CountW-1:0] bc_q, bc_d;
  rsp_t              rsp_q, rsp_d;

  logic [IdxW-1:0]   start_pos;
  logic [SizeW-1:0]  rd_val;
  logic              fits, better, take;
  logic [CountW-1:0] pos_inc, grant_inc;
  logic [IdxW-1:0]   pos_wrap, grant_wrap;
  logic [SizeW-1:0]  remain;

  // scan compare and pointer arithmetic
  always_comb begin
    start_pos  = ({1'b0, np_q} < bc_q) ? np_q : '0;
    rd_val     = blk_free_q[pos_q];
    fits       = (rd_val >= req_q.request_size);
    better     = ((req_q.policy == POL_BEST)  && (rd_val < best_val_q)) ||
                 ((req_q.policy == POL_WORST) && (rd_val > best_val_q));
    take       = fits && (!found_q || better);
    pos_inc    = {1'b0, pos_q} + CountW'(1);
    pos_wrap   = (pos_inc == bc_q) ? '0 : pos_inc[IdxW-1:0];
    grant_inc  = {1'b0, best_idx_q} + CountW'(1);
    grant_wrap = (grant_inc == bc_q) ? '0 : grant_inc[IdxW-1:0];
    remain     = best_val_q - req_q.request_size;
  end

  assign sts_o.scan_last = ({1'b0, cnt_q} == (bc_q - CountW'(1)));

  // scan state updates
  always_comb begin
    pos_d      = pos_q;
    cnt_d      = cnt_q;
    found_d    = found_q;
    best_idx_d = best_idx_q;
    best_val_d = best_val_q;
    if (cmd_i.capture) begin
      pos_d   = (req_i.policy == POL_NEXT) ? start_pos : '0;
      cnt_d   = '0;
      found_d = 1'b0;
    end else if (cmd_i.step) begin
      pos_d = pos_wrap;
      cnt_d = cnt_q + IdxW'(1);
      if (take) begin
        found_d    = 1'b1;
        best_idx_d = pos_q;
        best_val_d = rd_val;
      end
    end
  end

  // block count clamp and next-fit pointer reset on write, next-fit pointer advance on grant
  always_comb begin
    bc_d = bc_q;
    np_d = np_q;
    if (cfg_we_i) begin
      if (cfg_wdata_i == '0) begin
        bc_d = CountW'(1);
      end else if (cfg_wdata_i > CountW'(NumBlocks)) begin
        bc_d = CountW'(NumBlocks);
      end else begin
        bc_d = cfg_wdata_i;
      end
      np_d = '0;
    end else if (cmd_i.finish && found_q && (req_q.policy == POL_NEXT)) begin
      np_d = grant_wrap;
    end
  end

  // result formation
  always_comb begin
    rsp_d = rsp_q;
    if (cmd_i.load) begin
      rsp_d.status         = ST_LOADED;
      rsp_d.block_index    = req_i.load_index;
      rsp_d.remaining_size = req_i.load_size;
    end else if (cmd_i.finish) begin
      if (found_q) begin
        rsp_d.status         = ST_GRANTED;
        rsp_d.block_index    = best_idx_q;
        rsp_d.remaining_size = remain;
      end else begin
        rsp_d.status         = ST_REFUSED;
        rsp_d.block_index    = '0;
        rsp_d.remaining_size = '0;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
      pos_q   <= '0;
      cnt_q   <= '0;
      np_q    <= '0;
      bc_q    <= CountW'(NumBlocks);
    end else begin
      found_q <= found_d;
      pos_q   <= pos_d;
      cnt_q   <= cnt_d;
      np_q    <= np_d;
      bc_q    <= bc_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= req_i;
    end
    best_idx_q <= best_idx_d;
    best_val_q <= best_val_d;
    rsp_q      <= rsp_d;
  end

  // free-size table writes
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      blk_free_q[req_i.load_index] <= req_i.load_size;
    end else if (cmd_i.finish && found_q) begin
      blk_free_q[best_idx_q] <= remain;
    end
  end

  assign rsp_o = rsp_q;

endmodule

// ===== hw/rtl/fit_policy_block_allocator_unit.sv =====
// Fit-policy block allocator, top level: controller plus datapath.
// Load request: result in the next cycle after acceptance; busy stays low, so loads run every cycle.
// Allocate request: the scan compares one free-size table entry per cycle over all block_count
//   entries, then the grant is committed and the result registered.
// The next request is taken in the cycle its predecessor's result is shown.
// Reset: next-fit pointer 0, block count 16, free-size table undefined until loaded.
module fit_policy_block_allocator_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  fpba_pkg::req_t              req_i,
  input  logic                        cfg_we_i,
  input  logic [fpba_pkg::CountW-1:0] cfg_wdata_i,
  output logic                        done_o,
  output fpba_pkg::rsp_t              rsp_o
);
  import fpba_pkg::*;

  ctl_cmd_t ctl_cmd;
  dp_sts_t  dp_sts;

  // sequencing
  fpba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .req_alloc_i (req_i.cmd),
    .sts_i       (dp_sts),
    .cmd_o       (ctl_cmd),
    .busy        (busy),
    .done_o      (done_o)
  );

  // table, scan and result datapath
  fpba_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_i       (ctl_cmd),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sts_o       (dp_sts),
    .rsp_o       (rsp_o)
  );

endmodule

// ===== hw/rtl/fpba_checker.sv =====
// fpba_checker: port-level assertions for the fit-policy block allocator,
// bound to the top level. Depends on fpba_pkg.
module fpba_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start,
  input logic                        busy,
  input fpba_pkg::req_t              req_i,
  input logic                        done_o,
  input fpba_pkg::rsp_t              rsp_o
);
  import fpba_pkg::*;

  // a load request answers with a loaded result in the next cycle
  a_load_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (req_i.cmd == CMD_LOAD)) |=>
      (done_o && (rsp_o.status == ST_LOADED)))
    else $error("load request without loaded result");

  // an allocate request starts a scan
  a_alloc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (req_i.cmd == CMD_ALLOC)) |=> (busy && !done_o))
    else $error("allocate request did not start a scan");

  // the end of a scan always posts a result
  a_scan_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> (done_o && (rsp_o.status != ST_LOADED)))
    else $error("scan ended without allocate result");

  // a refused request reports no block and no size
  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (rsp_o.status == ST_REFUSED)) |->
      ((rsp_o.block_index == '0) && (rsp_o.remaining_size == '0)))
    else $error("refused result carries block data");

endmodule

bind fit_policy_block_allocator_unit fpba_checker u_fpba_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .req_i       (req_i),
  .done_o      (done_o),
  .rsp_o       (rsp_o)
);
